>>> hdl/sdcd_pkg.sv
// ----------------------------------------------------------------------------
// sdcd_pkg
// Shared types and constants for the serial drive command decoder.
// ----------------------------------------------------------------------------
package sdcd_pkg;

  localparam int BUFFER_LEN = 200;
  localparam int CNT_W      = $clog2(BUFFER_LEN);
  localparam int KEPT_BYTES = 4;
  localparam int IDX_W      = $clog2(KEPT_BYTES);
  localparam int TDATA_W    = 24;

  localparam logic [7:0] TERMINATOR  = 8'h3B;
  localparam logic [7:0] CENTRE      = 8'd127;

  // Command letters
  localparam logic [7:0] CMD_GO      = 8'h67;  // 'g'
  localparam logic [7:0] CMD_GO_2ND  = 8'h6F;  // 'o'
  localparam logic [7:0] CMD_STOP    = 8'h73;  // 's'
  localparam logic [7:0] CMD_A       = 8'h61;  // 'a'
  localparam logic [7:0] CMD_B       = 8'h62;  // 'b'
  localparam logic [7:0] CMD_LEFT    = 8'h6C;  // 'l'
  localparam logic [7:0] CMD_RIGHT   = 8'h72;  // 'r'

  localparam logic signed [1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [1:0] DIR_REV  = 2'sb11;
  localparam logic signed [1:0] DIR_STOP = 2'sb00;

  typedef struct packed {
    logic signed [8:0] speed_target;
    logic signed [1:0] master_dir;
    logic signed [1:0] slave_dir;
    logic [7:0]        drive_byte;
    logic              send_message;
    logic              command_done;
  } res_t;

endpackage

>>> hdl/sdcd_core.sv
// ----------------------------------------------------------------------------
// sdcd_core
// Command buffer, drive state and the per-beat decode of one received byte.
// ----------------------------------------------------------------------------
module sdcd_core
  import sdcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  logic [7:0]        cmd_r   [KEPT_BYTES];
  logic [7:0]        cmd_nxt [KEPT_BYTES];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              mode_r, mode_nxt;
  logic signed [1:0] mdir_r, mdir_nxt;
  logic signed [1:0] sdir_r, sdir_nxt;
  logic signed [8:0] speed_r, speed_nxt;
  logic [7:0]        bus_r, bus_nxt;

  logic [7:0]        go_val;
  logic signed [8:0] bus_diff;
  logic [8:0]        bus_dev;
  logic [8:0]        speed_abs;
  logic [CNT_W:0]    count_inc;
  logic              send;
  logic              done;
  logic              steer;
  logic signed [1:0] steer_m, steer_s;

  always_comb begin
    go_val    = 8'({cmd_r[2][3:0], 3'b000}) + 8'({cmd_r[2][3:0], 1'b0})
              + 8'(cmd_r[3][3:0]);
    bus_diff  = $signed({1'b0, bus_r}) - $signed({1'b0, CENTRE});
    bus_dev   = bus_diff[8] ? 9'(-bus_diff) : 9'(bus_diff);
    speed_abs = speed_r[8] ? 9'(-speed_r) : 9'(speed_r);
    count_inc = {1'b0, count_r} + (CNT_W+1)'(1);

    cmd_nxt   = cmd_r;
    count_nxt = count_r;
    mode_nxt  = mode_r;
    mdir_nxt  = mdir_r;
    sdir_nxt  = sdir_r;
    speed_nxt = speed_r;
    bus_nxt   = bus_r;
    send      = 1'b0;
    done      = 1'b0;
    steer     = 1'b0;
    steer_m   = DIR_STOP;
    steer_s   = DIR_STOP;

    if (rx_byte == TERMINATOR) begin
      done      = 1'b1;
      count_nxt = '0;
      unique case (cmd_r[0])
        CMD_GO: begin
          if (cmd_r[1] == CMD_GO_2ND) begin
            unique case (mdir_r)
              DIR_FWD: speed_nxt = $signed({1'b0, go_val});
              DIR_REV: speed_nxt = $signed(9'(-{1'b0, go_val}));
              default: speed_nxt = '0;
            endcase
            unique case (sdir_r)
              DIR_FWD: bus_nxt = CENTRE + go_val;
              DIR_REV: bus_nxt = CENTRE - go_val;
              default: bus_nxt = CENTRE;
            endcase
            send     = 1'b1;
            mode_nxt = 1'b1;
          end
        end
        CMD_STOP: begin
          mdir_nxt  = DIR_STOP;
          sdir_nxt  = DIR_STOP;
          speed_nxt = '0;
          bus_nxt   = CENTRE;
          send      = 1'b1;
        end
        CMD_A: begin
          steer = 1'b1; steer_m = DIR_FWD; steer_s = DIR_REV;
        end
        CMD_B: begin
          steer = 1'b1; steer_m = DIR_REV; steer_s = DIR_FWD;
        end
        CMD_LEFT: begin
          steer = 1'b1; steer_m = DIR_FWD; steer_s = DIR_FWD;
        end
        CMD_RIGHT: begin
          steer = 1'b1; steer_m = DIR_REV; steer_s = DIR_REV;
        end
        default: ;
      endcase
      if (steer) begin
        mdir_nxt = steer_m;
        sdir_nxt = steer_s;
        // re-sign the speed and reflect the drive byte about the centre
        if (mode_r) begin
          speed_nxt = (steer_m == DIR_FWD) ? $signed(speed_abs) : $signed(9'(-speed_abs));
          bus_nxt   = (steer_s == DIR_FWD) ? CENTRE + bus_dev[7:0] : CENTRE - bus_dev[7:0];
          send      = 1'b1;
        end
      end
    end else begin
      if (count_r < CNT_W'(KEPT_BYTES)) begin
        cmd_nxt[count_r[IDX_W-1:0]] = rx_byte;
      end
      count_nxt = (count_inc >= (CNT_W+1)'(BUFFER_LEN)) ? '0 : count_inc[CNT_W-1:0];
    end

    res.speed_target = speed_nxt;
    res.master_dir   = mdir_nxt;
    res.slave_dir    = sdir_nxt;
    res.drive_byte   = bus_nxt;
    res.send_message = send;
    res.command_done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEPT_BYTES; i++) begin
        cmd_r[i] <= '0;
      end
      count_r <= '0;
      mode_r  <= 1'b0;
      mdir_r  <= DIR_STOP;
      sdir_r  <= DIR_STOP;
      speed_r <= '0;
      bus_r   <= CENTRE;
    end else if (fire) begin
      cmd_r   <= cmd_nxt;
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
      mdir_r  <= mdir_nxt;
      sdir_r  <= sdir_nxt;
      speed_r <= speed_nxt;
      bus_r   <= bus_nxt;
    end
  end

endmodule

>>> hdl/serial_drive_command_decoder_top.sv
// ----------------------------------------------------------------------------
// serial_drive_command_decoder_top
// Decodes drive commands from received serial bytes, one result per byte.
// ----------------------------------------------------------------------------
// Each byte is held in the input register, decoded combinationally and then
// held in the result register; a stalled output (out_tready low) holds both.
// Throughput: one byte per cycle unless the output stalls (single decode stage).
// Reset (rst_n, synchronous, active low) empties both registers, clears the
// command buffer and drive state and sets the drive byte to 127.
module serial_drive_command_decoder_top
  import sdcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] rx_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [8:0] speed_target, [10:9] master_dir,
                                         // [12:11] slave_dir, [20:13] drive_byte
  output logic               out_tuser,  // [0] send_message
  output logic               out_tlast   // command_done
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  res_t       out_res_r;
  res_t       res;
  logic       adv;
  logic       fire;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign fire      = in_vld_r && adv;

  sdcd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_res_r.drive_byte, out_res_r.slave_dir,
                       out_res_r.master_dir, out_res_r.speed_target};
  assign out_tuser  = out_res_r.send_message;
  assign out_tlast  = out_res_r.command_done;

endmodule
